@@ rtl/ts_pes_pkg.sv @@
package ts_pes_pkg;

  // Width of the PES length counter
  localparam int LENGTH_BITS = 24;

  // PCR split: count / 300 gives the base, count % 300 the extension
  localparam int PCR_BITS      = 42;
  localparam int PCR_QUO_BITS  = 33;
  localparam int PCR_EXT_BITS  = 9;
  localparam logic [PCR_EXT_BITS-1:0] PCR_DIV = 9'd300;

  // count / 300 == (count >> 2) / 75, done as a multiply by a rounded-up
  // reciprocal of 75 and a right shift; exact for every 40-bit operand
  localparam int PCR_Y_BITS  = PCR_BITS - 2;
  localparam int HALF_BITS   = PCR_Y_BITS / 2;
  localparam int RECIP_SHIFT = 46;
  localparam logic [PCR_Y_BITS-1:0] RECIP_75 = 40'd938249922369;

  // Transport packet constants
  localparam logic [7:0] TS_SYNC    = 8'h47;
  localparam logic [7:0] CAP_PCR    = 8'd176;
  localparam logic [7:0] CAP_AF     = 8'd182;
  localparam logic [7:0] CAP_FULL   = 8'd184;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [7:0] FLAG_RAI   = 8'h40;
  localparam logic [7:0] FLAG_PCR   = 8'h10;
  localparam logic [7:0] PCR_RSV    = 8'h7E;
  localparam logic [7:0] PCR_AF_LEN = 8'd6;

  // AF control field codes
  localparam logic [1:0] AFC_PAYLOAD = 2'd1;
  localparam logic [1:0] AFC_AF_ONLY = 2'd2;
  localparam logic [1:0] AFC_BOTH    = 2'd3;

  // Job queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One job: a payload byte plus whatever packet header goes before it
  typedef struct packed {
    logic [7:0]              data;
    logic                    hdr;
    logic                    af;
    logic                    pcr;
    logic [7:0]              hdr_b1;
    logic [7:0]              hdr_b2;
    logic [7:0]              hdr_b3;
    logic [7:0]              af_len;
    logic [7:0]              af_flags;
    logic [7:0]              stuff;
    logic                    pkt_end;
    logic                    pes_end;
    logic [PCR_QUO_BITS-1:0] pcr_quo;
    logic [PCR_EXT_BITS-1:0] pcr_ext;
  } job_t;

endpackage

@@ rtl/ts_pes_div.sv @@
module ts_pes_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ts_pes_pkg::PCR_BITS-1:0]     dividend,
  output logic                                busy,
  output logic [ts_pes_pkg::PCR_QUO_BITS-1:0] quotient,
  output logic [ts_pes_pkg::PCR_EXT_BITS-1:0] remainder
);
  import ts_pes_pkg::*;

  logic [2:0]                  phase;
  logic [PCR_BITS-1:0]         num;
  logic [PCR_Y_BITS-1:0]       y;
  logic [2*HALF_BITS-1:0]      p_hh;
  logic [2*HALF_BITS-1:0]      p_hl;
  logic [2*HALF_BITS-1:0]      p_lh;
  logic [2*HALF_BITS-1:0]      p_ll;
  logic [2*PCR_Y_BITS-1:0]     prod;
  logic [PCR_QUO_BITS-1:0]     quo;
  logic [2*PCR_EXT_BITS-1:0]   quo_x300;
  logic [PCR_EXT_BITS-1:0]     rem;

  // Sum of the partial products; low quotient bits times 300 for the remainder
  always_comb begin
    y        = num[PCR_BITS-1:2];
    prod     = {p_hh, {PCR_Y_BITS{1'b0}}} +
               {{HALF_BITS{1'b0}}, p_hl, {HALF_BITS{1'b0}}} +
               {{HALF_BITS{1'b0}}, p_lh, {HALF_BITS{1'b0}}} +
               {{PCR_Y_BITS{1'b0}}, p_ll};
    quo_x300 = (2*PCR_EXT_BITS)'(quo[PCR_EXT_BITS-1:0]) * (2*PCR_EXT_BITS)'(PCR_DIV);
  end

  // Three steps: partial products, quotient, remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (start) begin
      phase <= 3'b001;
    end else begin
      phase <= {phase[1:0], 1'b0};
    end
  end

  // Quotient keeps its low 33 bits only, which is the base mask
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (phase[0]) begin
      p_hh <= (2*HALF_BITS)'(y[PCR_Y_BITS-1:HALF_BITS]) *
              (2*HALF_BITS)'(RECIP_75[PCR_Y_BITS-1:HALF_BITS]);
      p_hl <= (2*HALF_BITS)'(y[PCR_Y_BITS-1:HALF_BITS]) *
              (2*HALF_BITS)'(RECIP_75[HALF_BITS-1:0]);
      p_lh <= (2*HALF_BITS)'(y[HALF_BITS-1:0]) *
              (2*HALF_BITS)'(RECIP_75[PCR_Y_BITS-1:HALF_BITS]);
      p_ll <= (2*HALF_BITS)'(y[HALF_BITS-1:0]) *
              (2*HALF_BITS)'(RECIP_75[HALF_BITS-1:0]);
    end
    if (phase[1]) begin
      quo <= prod[RECIP_SHIFT+PCR_QUO_BITS-1:RECIP_SHIFT];
    end
    // remainder is below 512, so 9-bit arithmetic is exact
    if (phase[2]) begin
      rem <= num[PCR_EXT_BITS-1:0] - quo_x300[PCR_EXT_BITS-1:0];
    end
  end

  assign busy      = phase != '0;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ rtl/ts_pes_front.sv @@
module ts_pes_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      pes_byte,
  input  logic                            start_of_pes,
  input  logic [23:0]                     pes_length,
  input  logic [12:0]                     stream_pid,
  input  logic                            pcr_present,
  input  logic                            keyframe,
  input  logic [ts_pes_pkg::PCR_BITS-1:0] pcr_count,
  input  logic [3:0]                      first_cc,
  input  logic                            push,
  output logic                            full,
  output logic                            job_push,
  output ts_pes_pkg::job_t                job,
  input  logic                            job_full
);
  import ts_pes_pkg::*;

  // Packetizer state
  logic [LENGTH_BITS-1:0] bytes_remaining;
  logic [7:0]             payload_left_in_packet;
  logic [3:0]             cont_counter;
  logic [12:0]            held_pid;

  // Classified item waiting to enter the queue
  job_t pend;
  logic pend_valid;

  logic                    accept;
  logic                    div_busy;
  logic [PCR_QUO_BITS-1:0] div_quo;
  logic [PCR_EXT_BITS-1:0] div_rem;

  logic [LENGTH_BITS-1:0] br_in;
  logic [LENGTH_BITS-1:0] br_after;
  logic [7:0]             pl_in;
  logic [7:0]             pl_cur;
  logic [7:0]             pl_after;
  logic [3:0]             cc_in;
  logic [12:0]            pid_in;
  logic                   has_work;
  logic                   begin_pkt;
  logic                   pcr;
  logic                   af;
  logic [7:0]             cap;
  logic [7:0]             pay;
  logic [7:0]             stuff;
  logic [1:0]             afc;
  job_t                   job_d;

  assign accept   = push && !full;
  assign job_push = pend_valid && !(pend.pcr && div_busy) && !job_full;
  assign full     = pend_valid && !job_push;

  // Classify the incoming byte against the current packet state
  always_comb begin
    br_in     = start_of_pes ? LENGTH_BITS'(pes_length) : bytes_remaining;
    pl_in     = start_of_pes ? 8'd0 : payload_left_in_packet;
    cc_in     = start_of_pes ? first_cc : cont_counter;
    pid_in    = start_of_pes ? stream_pid : held_pid;
    has_work  = br_in != '0;
    begin_pkt = pl_in == 8'd0;
    pcr       = start_of_pes && pcr_present;

    if (pcr) begin
      af  = 1'b1;
      cap = CAP_PCR;
    end else if (start_of_pes) begin
      af  = 1'b1;
      cap = CAP_AF;
    end else if (br_in < LENGTH_BITS'(CAP_FULL)) begin
      af  = 1'b1;
      cap = CAP_AF;
    end else begin
      af  = 1'b0;
      cap = CAP_FULL;
    end

    pay      = (br_in < LENGTH_BITS'(cap)) ? br_in[7:0] : cap;
    stuff    = cap - pay;
    afc      = af ? ((pay != 8'd0) ? AFC_BOTH : AFC_AF_ONLY) : AFC_PAYLOAD;
    pl_cur   = begin_pkt ? pay : pl_in;
    pl_after = pl_cur - 8'd1;
    br_after = br_in - 1'b1;

    job_d          = '0;
    job_d.data     = pes_byte;
    job_d.hdr      = begin_pkt;
    job_d.af       = begin_pkt && af;
    job_d.pcr      = pcr;
    job_d.hdr_b1   = {1'b0, start_of_pes, 1'b0, pid_in[12:8]};
    job_d.hdr_b2   = pid_in[7:0];
    job_d.hdr_b3   = {2'b00, afc, cc_in};
    job_d.af_len   = 8'd1 + (pcr ? PCR_AF_LEN : 8'd0) + stuff;
    job_d.af_flags = ((start_of_pes && keyframe) ? FLAG_RAI : 8'd0) |
                     (pcr ? FLAG_PCR : 8'd0);
    job_d.stuff    = stuff;
    job_d.pkt_end  = pl_after == 8'd0;
    job_d.pes_end  = br_after == '0;
  end

  // State update per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining        <= '0;
      payload_left_in_packet <= '0;
      cont_counter           <= '0;
      held_pid               <= '0;
    end else if (accept) begin
      if (has_work) begin
        bytes_remaining        <= br_after;
        payload_left_in_packet <= (br_after == '0) ? 8'd0 : pl_after;
        held_pid               <= pid_in;
        cont_counter           <= begin_pkt ? cc_in + 4'd1 : cc_in;
      end else if (start_of_pes) begin
        bytes_remaining        <= '0;
        payload_left_in_packet <= '0;
      end
    end
  end

  // Job holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && has_work) begin
      pend_valid <= 1'b1;
    end else if (job_push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_work) begin
      pend <= job_d;
    end
  end

  ts_pes_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && has_work && pcr),
    .dividend  (pcr_count),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Queue entry takes the PCR split from the divider
  always_comb begin
    job         = pend;
    job.pcr_quo = div_quo;
    job.pcr_ext = div_rem;
  end

endmodule

@@ rtl/ts_pes_fifo.sv @@
module ts_pes_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  ts_pes_pkg::job_t din,
  output logic             full,
  input  logic             rd,
  output ts_pes_pkg::job_t dout,
  output logic             empty
);
  import ts_pes_pkg::*;

  job_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full  = count == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

@@ rtl/ts_pes_back.sv @@
module ts_pes_back (
  input  logic             clk,
  input  logic             rst,
  input  ts_pes_pkg::job_t job,
  input  logic             job_empty,
  output logic             job_pop,
  output logic [7:0]       out_byte,
  output logic [7:0]       repeat_count,
  output logic             packet_end,
  output logic             pes_end,
  output logic             item_end,
  output logic             empty,
  input  logic             pop
);
  import ts_pes_pkg::*;

  typedef enum logic [3:0] {
    ST_SYNC,
    ST_PID_HI,
    ST_PID_LO,
    ST_AFC_CC,
    ST_AF_LEN,
    ST_AF_FLAGS,
    ST_PCR0,
    ST_PCR1,
    ST_PCR2,
    ST_PCR3,
    ST_PCR4,
    ST_PCR5,
    ST_STUFF,
    ST_PAYLOAD
  } step_t;

  step_t      step;
  step_t      cur;
  step_t      step_next;
  logic       out_valid;
  logic       adv;
  logic [7:0] byte_sel;
  logic [7:0] rep_sel;
  logic       last_sel;

  // Output register frees up when empty or being drained
  assign adv     = !job_empty && (!out_valid || pop);
  assign job_pop = adv && last_sel;
  assign empty   = !out_valid;

  // Byte for the current step and the step after it
  always_comb begin
    cur      = (step == ST_SYNC && !job.hdr) ? ST_PAYLOAD : step;
    rep_sel  = 8'd1;
    last_sel = 1'b0;
    unique case (cur)
      ST_SYNC: begin
        byte_sel  = TS_SYNC;
        step_next = ST_PID_HI;
      end
      ST_PID_HI: begin
        byte_sel  = job.hdr_b1;
        step_next = ST_PID_LO;
      end
      ST_PID_LO: begin
        byte_sel  = job.hdr_b2;
        step_next = ST_AFC_CC;
      end
      ST_AFC_CC: begin
        byte_sel  = job.hdr_b3;
        step_next = job.af ? ST_AF_LEN : ST_PAYLOAD;
      end
      ST_AF_LEN: begin
        byte_sel  = job.af_len;
        step_next = ST_AF_FLAGS;
      end
      ST_AF_FLAGS: begin
        byte_sel  = job.af_flags;
        step_next = job.pcr ? ST_PCR0 :
                    ((job.stuff != 8'd0) ? ST_STUFF : ST_PAYLOAD);
      end
      ST_PCR0: begin
        byte_sel  = job.pcr_quo[32:25];
        step_next = ST_PCR1;
      end
      ST_PCR1: begin
        byte_sel  = job.pcr_quo[24:17];
        step_next = ST_PCR2;
      end
      ST_PCR2: begin
        byte_sel  = job.pcr_quo[16:9];
        step_next = ST_PCR3;
      end
      ST_PCR3: begin
        byte_sel  = job.pcr_quo[8:1];
        step_next = ST_PCR4;
      end
      ST_PCR4: begin
        byte_sel  = {job.pcr_quo[0], PCR_RSV[6:1], job.pcr_ext[8]};
        step_next = ST_PCR5;
      end
      ST_PCR5: begin
        byte_sel  = job.pcr_ext[7:0];
        step_next = (job.stuff != 8'd0) ? ST_STUFF : ST_PAYLOAD;
      end
      ST_STUFF: begin
        byte_sel  = STUFF_BYTE;
        rep_sel   = job.stuff;
        step_next = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        byte_sel  = job.data;
        last_sel  = 1'b1;
        step_next = ST_SYNC;
      end
      default: begin
        byte_sel  = job.data;
        step_next = ST_SYNC;
      end
    endcase
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_SYNC;
      out_valid    <= 1'b0;
      out_byte     <= '0;
      repeat_count <= '0;
      packet_end   <= 1'b0;
      pes_end      <= 1'b0;
      item_end     <= 1'b0;
    end else if (adv) begin
      step         <= step_next;
      out_valid    <= 1'b1;
      out_byte     <= byte_sel;
      repeat_count <= rep_sel;
      packet_end   <= last_sel && job.pkt_end;
      pes_end      <= last_sel && job.pes_end;
      item_end     <= last_sel;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/ts_pes_packetizer_unit.sv @@
// Channel   Direction  Handshake            Fields
// input     in         push / full          pes_byte, start_of_pes, pes_length, stream_pid,
//                                           pcr_present, keyframe, pcr_count, first_cc
// result    out        empty / pop          out_byte, repeat_count, packet_end, pes_end,
//                                           item_end
//
// A byte inside a packet gives one result; a byte that opens a packet gives one result per
// header step (up to 14); the back-end sequencer issues one per cycle unless pop or the job queue stalls it.
// A byte with a PCR holds the front end until the reciprocal divide by 300 is done.
// A four-entry job queue lets the front keep taking bytes while the back stalls on pop.
// Synchronous reset clears the control state but not every data register; no clearing pass.
module ts_pes_packetizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      pes_byte,
  input  logic                            start_of_pes,
  input  logic [23:0]                     pes_length,
  input  logic [12:0]                     stream_pid,
  input  logic                            pcr_present,
  input  logic                            keyframe,
  input  logic [ts_pes_pkg::PCR_BITS-1:0] pcr_count,
  input  logic [3:0]                      first_cc,
  input  logic                            push,
  output logic                            full,
  output logic [7:0]                      out_byte,
  output logic [7:0]                      repeat_count,
  output logic                            packet_end,
  output logic                            pes_end,
  output logic                            item_end,
  output logic                            empty,
  input  logic                            pop
);
  import ts_pes_pkg::*;

  job_t job_in;
  job_t job_out;
  logic job_push;
  logic job_full;
  logic job_empty;
  logic job_pop;

  ts_pes_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pes_byte     (pes_byte),
    .start_of_pes (start_of_pes),
    .pes_length   (pes_length),
    .stream_pid   (stream_pid),
    .pcr_present  (pcr_present),
    .keyframe     (keyframe),
    .pcr_count    (pcr_count),
    .first_cc     (first_cc),
    .push         (push),
    .full         (full),
    .job_push     (job_push),
    .job          (job_in),
    .job_full     (job_full)
  );

  ts_pes_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .din   (job_in),
    .full  (job_full),
    .rd    (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  ts_pes_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (job_out),
    .job_empty    (job_empty),
    .job_pop      (job_pop),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .packet_end   (packet_end),
    .pes_end      (pes_end),
    .item_end     (item_end),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

@@ verif/ts_pes_packetizer_unit_test.sv @@
module ts_pes_packetizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ts_pes_pkg::*;

  // Total input requests for the run
  localparam int N_ITEMS = 500;

  // One input request as driven on the push side
  typedef struct packed {
    logic [7:0]          data;
    logic                sop;
    logic [23:0]         len;
    logic [12:0]         pid;
    logic                pcr;
    logic                key;
    logic [PCR_BITS-1:0] pcr_cnt;
    logic [3:0]          cc;
  } pes_item_t;

  // One transport stream result as seen on the pop side
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] rep;
    logic       pkt_end;
    logic       pes_end;
    logic       item_end;
  } ts_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [7:0]          pes_byte = '0;
  logic                start_of_pes = 1'b0;
  logic [23:0]         pes_length = '0;
  logic [12:0]         stream_pid = '0;
  logic                pcr_present = 1'b0;
  logic                keyframe = 1'b0;
  logic [PCR_BITS-1:0] pcr_count = '0;
  logic [3:0]          first_cc = '0;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          out_byte;
  logic [7:0]          repeat_count;
  logic                packet_end;
  logic                pes_end;
  logic                item_end;
  logic                empty;
  logic                pop = 1'b0;

  ts_pes_packetizer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .pes_byte     (pes_byte),
    .start_of_pes (start_of_pes),
    .pes_length   (pes_length),
    .stream_pid   (stream_pid),
    .pcr_present  (pcr_present),
    .keyframe     (keyframe),
    .pcr_count    (pcr_count),
    .first_cc     (first_cc),
    .push         (push),
    .full         (full),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .packet_end   (packet_end),
    .pes_end      (pes_end),
    .item_end     (item_end),
    .empty        (empty),
    .pop          (pop)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Packetizer state mirrored by the predictor
  logic [LENGTH_BITS-1:0] pes_left = '0;
  logic [7:0]             pkt_room = '0;
  logic [3:0]             cc_next = '0;
  logic [12:0]            cur_pid = '0;

  ts_result_t ts_stream_q[$];

  int n_errors = 0;
  int n_results = 0;
  int n_packets = 0;
  int n_pes_started = 0;
  int n_pes_done = 0;
  int n_payload = 0;
  int n_items = 0;
  int burst_left = 0;

  function automatic void queue_result(input logic [7:0] v, input logic [7:0] r);
    ts_result_t res;
    res = {v, r, 3'b000};
    ts_stream_q.insert(ts_stream_q.size(), res);
  endfunction

  // Header plus adaptation field in front of the byte that opens a packet
  function automatic void open_packet(input logic first, input logic with_pcr,
                                      input logic key, input logic [PCR_BITS-1:0] cnt);
    logic                    af;
    int                      cap;
    int                      rem;
    int                      pay;
    int                      stuff;
    logic [1:0]              afc;
    logic [PCR_BITS-1:0]     quot;
    logic [PCR_BITS-1:0]     modv;
    logic [PCR_QUO_BITS-1:0] base;
    logic [PCR_EXT_BITS-1:0] ext;
    rem = int'(pes_left);
    af  = with_pcr || first;
    cap = with_pcr ? int'(CAP_PCR) : first ? int'(CAP_AF) : int'(CAP_FULL);
    // short last packet gets an adaptation field for stuffing
    if (!af && rem < cap) begin
      af  = 1'b1;
      cap = int'(CAP_AF);
    end
    pay   = rem < cap ? rem : cap;
    stuff = cap - pay;
    afc   = !af ? AFC_PAYLOAD : (pay > 0 ? AFC_BOTH : AFC_AF_ONLY);

    queue_result(TS_SYNC, 8'd1);
    queue_result({1'b0, first, 1'b0, cur_pid[12:8]}, 8'd1);
    queue_result(cur_pid[7:0], 8'd1);
    queue_result({2'b00, afc, cc_next}, 8'd1);
    cc_next = cc_next + 4'd1;

    if (af) begin
      queue_result(8'(1 + (with_pcr ? int'(PCR_AF_LEN) : 0) + stuff), 8'd1);
      queue_result(((first && key) ? FLAG_RAI : 8'h00) | (with_pcr ? FLAG_PCR : 8'h00), 8'd1);
      if (with_pcr) begin
        quot = cnt / PCR_DIV;
        modv = cnt % PCR_DIV;
        base = quot[PCR_QUO_BITS-1:0];
        ext  = modv[PCR_EXT_BITS-1:0];
        queue_result(base[32:25], 8'd1);
        queue_result(base[24:17], 8'd1);
        queue_result(base[16:9], 8'd1);
        queue_result(base[8:1], 8'd1);
        queue_result(PCR_RSV | {base[0], 6'b000000, ext[8]}, 8'd1);
        queue_result(ext[7:0], 8'd1);
      end
      if (stuff > 0) queue_result(STUFF_BYTE, 8'(stuff));
    end
    pkt_room = 8'(pay);
  endfunction

  // Expected results for one accepted request; returns 1 if it produced any
  function automatic bit packetize_item(input pes_item_t it);
    ts_result_t r;
    if (it.sop) begin
      pes_left = it.len[LENGTH_BITS-1:0];
      pkt_room = '0;
      if (pes_left == 0) return 1'b0;
      cur_pid = it.pid;
      cc_next = it.cc;
      n_pes_started++;
      open_packet(1'b1, it.pcr, it.key, it.pcr_cnt);
    end else begin
      if (pes_left == 0) return 1'b0;
      if (pkt_room == 0) open_packet(1'b0, 1'b0, 1'b0, '0);
    end
    pkt_room--;
    pes_left--;
    r.value    = it.data;
    r.rep      = 8'd1;
    r.pkt_end  = (pkt_room == 0);
    r.pes_end  = (pes_left == 0);
    r.item_end = 1'b1;
    ts_stream_q.insert(ts_stream_q.size(), r);
    if (pes_left == 0) pkt_room = '0;
    return 1'b1;
  endfunction

  function automatic logic [PCR_BITS-1:0] rand_pcr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[PCR_BITS-1:0];
  endfunction

  // Random content in every field, not a PES start
  function automatic pes_item_t noise_item();
    pes_item_t it;
    it.data    = 8'($urandom());
    it.sop     = 1'b0;
    it.len     = 24'($urandom());
    it.pid     = 13'($urandom());
    it.pcr     = 1'($urandom());
    it.key     = 1'($urandom());
    it.pcr_cnt = rand_pcr();
    it.cc      = 4'($urandom());
    return it;
  endfunction

  // Drive one request, wait for it to be taken, then maybe idle between bursts
  task automatic send_item(input pes_item_t it);
    pes_byte     <= it.data;
    start_of_pes <= it.sop;
    pes_length   <= it.len;
    stream_pid   <= it.pid;
    pcr_present  <= it.pcr;
    keyframe     <= it.key;
    pcr_count    <= it.pcr_cnt;
    first_cc     <= it.cc;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    n_items++;
    if (packetize_item(it)) n_payload++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(150, 50) : $urandom_range(12, 0);
    end
  endtask

  // Send the first n_send bytes of a PES of length len
  task automatic send_pes(input int len, input int n_send, input logic with_pcr,
                          input logic key, input logic [12:0] pid, input logic [3:0] cc,
                          input logic [PCR_BITS-1:0] cnt);
    pes_item_t it;
    for (int i = 0; i < n_send; i++) begin
      it = noise_item();
      if (i == 0) begin
        it.sop     = 1'b1;
        it.len     = 24'(len);
        it.pid     = pid;
        it.pcr     = with_pcr;
        it.key     = key;
        it.pcr_cnt = cnt;
        it.cc      = cc;
      end
      send_item(it);
    end
  endtask

  // Header fields at their extremes, RAI and PCR on and off, max stuffing
  task automatic test_header_fields();
    send_pes(1, 1, 1'b1, 1'b1, 13'h1FFF, 4'hF, {PCR_BITS{1'b1}});
    send_pes(1, 1, 1'b0, 1'b0, 13'h0000, 4'h0, '0);
    send_pes(3, 3, 1'b0, 1'b1, 13'h0A5A, 4'h7, rand_pcr());
    send_pes(2, 2, 1'b1, 1'b0, 13'h15A5, 4'h8, 42'd299);
  endtask

  // Zero-length start and bytes with no open PES produce nothing
  task automatic test_zero_and_idle();
    pes_item_t it;
    it     = noise_item();
    it.sop = 1'b1;
    it.len = '0;
    send_item(it);
    send_item(noise_item());
    send_pes(1, 1, 1'b0, 1'b1, 13'h0100, 4'h3, '0);
    send_item(noise_item());
  endtask

  // A new start abandons an open PES, including right after its first byte
  task automatic test_restart();
    send_pes(24'hFFFFFF, 3, 1'b1, 1'b1, 13'h1ABC, 4'hE, rand_pcr());
    send_pes(5, 1, 1'b0, 1'b0, 13'h0042, 4'h1, '0);
    send_pes(2, 2, 1'b0, 1'b0, 13'h0043, 4'h9, '0);
  endtask

  // PCR packet full, then 183 bytes left: stuffing-free AF packet plus one spilled byte
  task automatic test_packet_boundaries();
    send_pes(359, 359, 1'b1, 1'b0, 13'($urandom()), 4'($urandom()), rand_pcr());
  endtask

  task automatic random_pes();
    int        pick;
    int        len;
    int        n_send;
    pes_item_t it;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_item(noise_item());
      return;
    end
    if (pick < 6) begin
      it     = noise_item();
      it.sop = 1'b1;
      it.len = '0;
      send_item(it);
      return;
    end
    if (pick < 12) begin
      // random length up to the 24-bit maximum, of which only one to four bytes are sent
      len    = $urandom_range(24'hFFFFFF, 1);
      n_send = $urandom_range(4, 1);
    end else if (pick < 20) begin
      len    = $urandom_range(200, 2);
      n_send = $urandom_range(len - 1, 1);
    end else if (pick < 28) begin
      len    = $urandom_range(186, 175);
      n_send = len;
    end else begin
      len    = $urandom_range(48, 1);
      n_send = len;
    end
    // keep the run near its request budget
    if (n_send > N_ITEMS - n_items) n_send = N_ITEMS - n_items;
    send_pes(len, n_send, 1'($urandom()), 1'($urandom()), 13'($urandom()),
             4'($urandom()), rand_pcr());
  endtask

  task automatic test_random_traffic();
    while (n_items < N_ITEMS) random_pes();
  endtask

  // Compare one popped result against the oldest expectation
  task automatic check_result();
    ts_result_t want;
    ts_result_t got;
    got = {out_byte, repeat_count, packet_end, pes_end, item_end};
    n_results++;
    if (ts_stream_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("ERROR: unexpected result byte=%02h rep=%0d pkt_end=%b pes_end=%b item_end=%b",
                 got.value, got.rep, got.pkt_end, got.pes_end, got.item_end);
      return;
    end
    want = ts_stream_q.pop_front();
    if (want.pkt_end) n_packets++;
    if (want.pes_end) n_pes_done++;
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 10) begin
        $display("ERROR: result %0d expected byte=%02h rep=%0d pkt_end=%b pes_end=%b item_end=%b",
                 n_results, want.value, want.rep, want.pkt_end, want.pes_end, want.item_end);
        $display("       got      byte=%02h rep=%0d pkt_end=%b pes_end=%b item_end=%b",
                 got.value, got.rep, got.pkt_end, got.pes_end, got.item_end);
      end
    end
  endtask

  // Pop side: check each popped result, under a stall pattern that is redrawn at random
  initial begin
    int rx_mode;
    int rx_cycle;
    rx_mode  = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_result();
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(3);
      rx_cycle++;
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom());
        2: pop <= ($urandom_range(5) == 0);
        default: pop <= ((rx_cycle / 8) % 2 == 0);
      endcase
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_header_fields();
    test_zero_and_idle();
    test_restart();
    test_packet_boundaries();
    test_random_traffic();
    push <= 1'b0;
    while (ts_stream_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests, %0d payload bytes over %0d PES starts, %0d PES completed",
             n_items, n_payload, n_pes_started, n_pes_done);
    $display("Checked %0d results, %0d complete packets, %0d mismatches",
             n_results, n_packets, n_errors);
    if (n_errors == 0 && ts_stream_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", ts_stream_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
